@@ hdl/dlhg_pkg.sv @@
package dlhg_pkg;

  localparam int CORE_W       = 3;
  localparam int LOAD_W       = 16;
  localparam int NLEV_W       = 5;
  localparam int LEVEL_OUT_W  = 4;
  localparam int S_TDATA_W    = 24;
  localparam int M_TDATA_W    = 8;
  localparam logic [NLEV_W-1:0] NUM_LEVELS_RESET = 5'd8;

  typedef struct packed {
    logic cap;
    logic req;
    logic cnt;
    logic cur;
    logic dec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic active;
  } dp_status_t;

endpackage

@@ hdl/dlhg_ctrl.sv @@
module dlhg_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  dlhg_pkg::dp_status_t  status,
  output dlhg_pkg::ctrl_cmd_t   cmd
);
  import dlhg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REQ,
    ST_CNT,
    ST_CUR,
    ST_DEC
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free     = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    cmd     = '0;
    cmd.cap = s_axis_tvalid && s_axis_tready;
    cmd.req = (state == ST_REQ);
    cmd.cnt = (state == ST_CNT);
    cmd.cur = (state == ST_CUR);
    cmd.dec = (state == ST_DEC) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cmd.dec) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_REQ;
          end
        end
        ST_REQ: begin
          state <= status.active ? ST_CNT : ST_DEC;
        end
        ST_CNT: begin
          state <= ST_CUR;
        end
        ST_CUR: begin
          state <= ST_DEC;
        end
        ST_DEC: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cap_to_req: assert property (@(posedge clk) disable iff (rst)
    cmd.cap |=> cmd.req)
    else $error("accepted transaction did not start the level request step");
  a_dec_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.dec |=> m_axis_tvalid)
    else $error("decision did not raise the output valid");
  a_ready_while_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.req || cmd.cnt || cmd.cur) |-> !s_axis_tready)
    else $error("input ready while a report is in progress");
`endif

endmodule

@@ hdl/dlhg_dp.sv @@
module dlhg_dp #(
  parameter int CORES      = 8,
  parameter int LEVELS     = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  dlhg_pkg::ctrl_cmd_t                   cmd,
  output dlhg_pkg::dp_status_t                  status,
  input  logic                                  cfg_we,
  input  logic [dlhg_pkg::NLEV_W-1:0]           cfg_wdata,
  input  logic [dlhg_pkg::CORE_W-1:0]           in_core,
  input  logic                                  in_prof,
  input  logic [dlhg_pkg::LOAD_W-1:0]           in_load,
  output logic [dlhg_pkg::CORE_W-1:0]           out_core,
  output logic                                  out_changed,
  output logic [dlhg_pkg::LEVEL_OUT_W-1:0]      out_level
);
  import dlhg_pkg::*;

  localparam int CW      = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int LW      = $clog2(LEVELS);
  localparam int NW      = $clog2(LEVELS + 1);
  localparam int ENTRIES = CORES * LEVELS;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW      = LOAD_W + NW;
  localparam int MW      = COUNT_BITS + LW;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [NLEV_W-1:0]     num_levels;
  logic [CORE_W-1:0]     core_r;
  logic                  prof_r;
  logic [LOAD_W-1:0]     load_r;

  logic [LW-1:0]         core_levels [CORES];
  logic [ENTRIES-1:0]    valid;
  logic [COUNT_BITS-1:0] mem [ENTRIES];
  logic [COUNT_BITS-1:0] rd_data;

  logic [NW-1:0]         n_eff;
  logic [PW-1:0]         load_prod;
  logic [NW-1:0]         req_raw;
  logic [LW-1:0]         req;
  logic [LW-1:0]         cur;
  logic [CW-1:0]         ci;
  logic                  in_range;
  logic [AW-1:0]         addr_req_now;
  logic [AW-1:0]         addr_cur_now;

  logic [LW-1:0]         req_r;
  logic [LW-1:0]         cur_r;
  logic [LW-1:0]         dist_r;
  logic [AW-1:0]         addr_req_r;
  logic [AW-1:0]         addr_cur_r;
  logic [COUNT_BITS-1:0] inc_r;
  logic [COUNT_BITS-1:0] cnt_cur_r;
  logic [MW-1:0]         prod_r;

  logic [COUNT_BITS-1:0] cnt_rd;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  changed;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;

  always_comb begin
    if (num_levels == '0) begin
      n_eff = NW'(1);
    end else if (int'(num_levels) > LEVELS) begin
      n_eff = NW'(LEVELS);
    end else begin
      n_eff = NW'(num_levels);
    end
  end

  assign load_prod = PW'(load_r) * PW'(n_eff);
  assign req_raw   = load_prod[PW-1:LOAD_W];
  assign req       = (req_raw > n_eff - NW'(1)) ? LW'(n_eff - NW'(1)) : LW'(req_raw);
  assign ci        = CW'(core_r);
  assign in_range  = (int'(core_r) < CORES);
  assign cur       = core_levels[ci];

  assign status.active = in_range && prof_r;

  assign addr_req_now = AW'(int'(ci) * LEVELS + int'(req));
  assign addr_cur_now = AW'(int'(ci) * LEVELS + int'(cur));

  assign cnt_rd  = valid[addr_req_r] ? rd_data : '0;
  assign cnt_inc = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + COUNT_BITS'(1);
  assign changed = status.active && (req_r != cur_r) && (prod_r > MW'(cnt_cur_r));

  assign rd_en   = cmd.req || cmd.cnt;
  assign rd_addr = cmd.req ? addr_req_now : addr_cur_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.cnt) begin
      mem[addr_req_r] <= cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      core_r <= in_core;
      prof_r <= in_prof;
      load_r <= in_load;
    end
    if (cmd.req) begin
      req_r      <= req;
      cur_r      <= cur;
      dist_r     <= (req > cur) ? req - cur : cur - req;
      addr_req_r <= addr_req_now;
      addr_cur_r <= addr_cur_now;
    end
    if (cmd.cnt) begin
      inc_r <= cnt_inc;
    end
    if (cmd.cur) begin
      cnt_cur_r <= valid[addr_cur_r] ? rd_data : '0;
      prod_r    <= MW'(inc_r) * MW'(dist_r);
    end
    if (cmd.dec) begin
      out_core    <= core_r;
      out_changed <= changed;
      if (!in_range) begin
        out_level <= '0;
      end else if (changed) begin
        out_level <= LEVEL_OUT_W'(req_r);
      end else begin
        out_level <= LEVEL_OUT_W'(cur_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_levels <= NUM_LEVELS_RESET;
      valid      <= '0;
      for (int c = 0; c < CORES; c++) begin
        core_levels[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        num_levels <= cfg_wdata;
      end
      if (cmd.cnt) begin
        valid[addr_req_r] <= 1'b1;
      end
      if (cmd.dec && changed) begin
        core_levels[ci] <= req_r;
        for (int i = 0; i < LEVELS; i++) begin
          if ((i < int'(n_eff)) && (LW'(i) != req_r)) begin
            valid[AW'(int'(ci) * LEVELS + i)] <= 1'b0;
          end
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_change_needs_active: assert property (@(posedge clk) disable iff (rst)
    (cmd.dec && changed) |-> (prof_r && in_range))
    else $error("level change on an ignored report");
  a_level_stored: assert property (@(posedge clk) disable iff (rst)
    (cmd.dec && changed) |=> (core_levels[$past(ci)] == $past(req_r)))
    else $error("switched level was not stored for the core");
  a_req_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.req |-> (NW'(req) < n_eff))
    else $error("requested level beyond the levels in use");
`endif

endmodule

@@ hdl/dvfs_level_hysteresis_governor.sv @@
// Each accepted report passes the request, count, current-level and decision states; ignored
// reports (not from the profiler, or an absent core) skip from request to decision. A new
// report is taken only after the last one leaves decision, which waits for output room;
// the sequencer reads the counter memory once for the requested and once for the current level.
// Reset is synchronous: all counters read as zero through per-entry valid bits, every core
// returns to level 0 and the level count returns to 8; no clearing pass is needed.
module dvfs_level_hysteresis_governor #(
  parameter int CORES      = 8,
  parameter int LEVELS     = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // core_id [2:0], load_fraction [18:3], zero [23:19]
  input  logic [dlhg_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // from_profiler [0]
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // core_out [2:0], current_level [6:3], zero [7]
  output logic [dlhg_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // level_changed [0]
  output logic                              m_axis_tuser,
  input  logic                              cfg_we,
  input  logic [dlhg_pkg::NLEV_W-1:0]       cfg_wdata
);
  import dlhg_pkg::*;

  ctrl_cmd_t              cmd;
  dp_status_t             status;
  logic [CORE_W-1:0]      out_core;
  logic [LEVEL_OUT_W-1:0] out_level;

  dlhg_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .status        (status),
    .cmd           (cmd)
  );

  dlhg_dp #(
    .CORES      (CORES),
    .LEVELS     (LEVELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_core     (s_axis_tdata[CORE_W-1:0]),
    .in_prof     (s_axis_tuser),
    .in_load     (s_axis_tdata[CORE_W+LOAD_W-1:CORE_W]),
    .out_core    (out_core),
    .out_changed (m_axis_tuser),
    .out_level   (out_level)
  );

  assign m_axis_tdata = {1'b0, out_level, out_core};

endmodule
